>>> rtl/skt_pkg.sv
// ============================================================================
// skt_pkg - shared types and constants of the sorted key table
// Opcodes, status codes, sequencer states and the result record passed from
// the sequencer to the output stage.
// ============================================================================
package skt_pkg;

  localparam int KEY_W   = 32;
  localparam int CNT_W   = 7;
  localparam int CNT_MAX = 127;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_COUNT  = 2'd2,
    OP_LIST   = 2'd3
  } skt_op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } skt_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_INS_SHIFT,
    S_INS_HEAD,
    S_SCAN,
    S_LIST,
    S_RESP
  } skt_state_t;

  typedef struct packed {
    skt_status_t              status;
    logic [CNT_W-1:0]         match_count;
    logic signed [KEY_W-1:0]  listed_key;
    logic                     last;
  } skt_res_t;

endpackage

>>> rtl/sorted_key_table_unit.sv
// ============================================================================
// sorted_key_table_unit - sorted multiset of signed account keys
// Holds up to DEPTH keys in ascending order in one memory; supports insert,
// delete of all matches, count of matches and an ordered listing.
// ============================================================================
// Usage. Commands arrive as transfers on the s_ channel: an opcode and a
// signed 32-bit key. Results leave as transfers on the m_ channel; insert,
// delete and count give one result each, list gives one result per stored
// key (or a single "table empty" result), and m_tlast marks the final
// result of each command.
// Sequencing. One command is worked on at a time; s_tready is high only
// while the sequencer waits for a command. The sequencer takes the
// command and sets up the memory walk. Insert then shifts the entries not
// below the new key up one slot and places the key, delete and count visit
// every stored entry, and list gives out one key per transfer; a single
// result then passes through the result state into the output register.
// The memory is visited one entry per cycle, while the receiver keeps up
// during a listing; this rate is set by the single read and single write
// port of the key memory.
// Reset clears the entry count, so the table is empty; the memory itself is
// not cleared, as entries beyond the count are never read.
// Stalls. The result sits in an output register, so the sequencer can hand
// over the next result in the cycle the current one is taken. While
// m_tready is low and the register is full the sequencer simply waits.
// ============================================================================
module sorted_key_table_unit
  import skt_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // opcode[1:0], account_key[33:2], zero[39:34]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // status[1:0], match_count[8:2], listed_key[40:9],
                                // zero[47:41]
  output logic        m_tlast   // last_of_run
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic             res_valid;
  logic             res_ready;
  skt_res_t         res;
  skt_res_t         out_res;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [KEY_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [KEY_W-1:0] ram_rdata;

  skt_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (skt_op_t'(s_tdata[1:0])),
    .in_key    ($signed(s_tdata[33:2])),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Key store: entries 0 to count-1 hold the keys in ascending order.
  skt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register: loads whenever it is empty or its contents are being
  // taken in the same cycle.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {7'd0, out_res.listed_key, out_res.match_count, out_res.status};
  assign m_tlast = out_res.last;

endmodule

>>> rtl/skt_ram.sv
// ============================================================================
// skt_ram - generic simple dual-port RAM
// One write port and one read port; the read data is registered and holds
// its value in cycles without a read.
// ============================================================================
module skt_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/skt_ctrl.sv
// ============================================================================
// skt_ctrl - sequencer of the sorted key table
// Walks the memory one entry per cycle, a listing only while res_ready is
// high: shifts up for insert, compacts for delete, counts matches, lists keys.
// ============================================================================
module skt_ctrl
  import skt_pkg::*;
#(
  parameter int  DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  skt_op_t                 in_op,
  input  logic signed [KEY_W-1:0] in_key,
  output logic                    res_valid,
  input  logic                    res_ready,
  output skt_res_t                res,
  output logic                    ram_we,
  output logic [AW-1:0]           ram_waddr,
  output logic [KEY_W-1:0]        ram_wdata,
  output logic                    ram_re,
  output logic [AW-1:0]           ram_raddr,
  input  logic [KEY_W-1:0]        ram_rdata
);

  localparam int MW = (CW > CNT_W) ? CW : CNT_W;

  skt_state_t              state, state_next;
  skt_op_t                 op, op_next;
  logic signed [KEY_W-1:0] key, key_next;
  logic [CW-1:0]           total, total_next;
  logic [CW-1:0]           rd_idx, rd_idx_next;
  logic [CW-1:0]           wr_idx, wr_idx_next;
  logic [CW-1:0]           cnt, cnt_next;
  skt_status_t             status, status_next;

  logic signed [KEY_W-1:0] rkey;
  logic                    match;
  logic                    key_ge;
  logic [CW-1:0]           total_m1;
  logic [CW-1:0]           wr_m2;
  logic [CW-1:0]           scan_cnt;
  logic [CW-1:0]           scan_wr;
  logic                    is_full;
  logic                    is_empty;
  logic                    scan_end;
  logic [MW-1:0]           cnt_ext;
  logic [CNT_W-1:0]        cnt_sat;

  assign rkey     = $signed(ram_rdata);
  assign match    = (rkey == key);
  assign key_ge   = (rkey >= key);
  assign total_m1 = total - CW'(1);
  assign wr_m2    = wr_idx - CW'(2);
  assign scan_cnt = cnt + CW'(match);
  assign scan_wr  = wr_idx + CW'(!match && (op == OP_DELETE));
  assign is_full  = (total == CW'(DEPTH));
  assign is_empty = (total == '0);
  assign scan_end = (rd_idx == total);
  assign cnt_ext  = MW'(cnt);
  assign cnt_sat  = (cnt_ext > MW'(CNT_MAX)) ? CNT_W'(CNT_MAX) : cnt_ext[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      total <= '0;
    end else begin
      state <= state_next;
      total <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    op     <= op_next;
    key    <= key_next;
    rd_idx <= rd_idx_next;
    wr_idx <= wr_idx_next;
    cnt    <= cnt_next;
    status <= status_next;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_START;
        end
      end
      S_START: begin
        case (op)
          OP_INSERT: begin
            if (is_full || is_empty) begin
              state_next = S_RESP;
            end else begin
              state_next = S_INS_SHIFT;
            end
          end
          OP_DELETE, OP_COUNT: begin
            state_next = is_empty ? S_RESP : S_SCAN;
          end
          default: begin
            state_next = is_empty ? S_RESP : S_LIST;
          end
        endcase
      end
      S_INS_SHIFT: begin
        if (!key_ge) begin
          state_next = S_RESP;
        end else if (wr_idx == CW'(1)) begin
          state_next = S_INS_HEAD;
        end
      end
      S_INS_HEAD: begin
        state_next = S_RESP;
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_RESP;
        end
      end
      S_LIST: begin
        if (res_ready && scan_end) begin
          state_next = S_IDLE;
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Datapath register updates.
  always_comb begin
    op_next     = op;
    key_next    = key;
    total_next  = total;
    rd_idx_next = rd_idx;
    wr_idx_next = wr_idx;
    cnt_next    = cnt;
    status_next = status;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next  = in_op;
          key_next = in_key;
        end
      end
      S_START: begin
        cnt_next    = '0;
        rd_idx_next = CW'(1);
        wr_idx_next = '0;
        case (op)
          OP_INSERT: begin
            if (is_full) begin
              status_next = ST_FULL;
            end else if (is_empty) begin
              status_next = ST_OK;
              total_next  = total + CW'(1);
            end else begin
              wr_idx_next = total;
            end
          end
          OP_DELETE, OP_COUNT: begin
            status_next = ST_NOTFOUND;
          end
          default: begin
            status_next = ST_EMPTY;
          end
        endcase
      end
      S_INS_SHIFT: begin
        if (!key_ge) begin
          status_next = ST_OK;
          total_next  = total + CW'(1);
        end else begin
          wr_idx_next = wr_idx - CW'(1);
        end
      end
      S_INS_HEAD: begin
        status_next = ST_OK;
        total_next  = total + CW'(1);
      end
      S_SCAN: begin
        cnt_next    = scan_cnt;
        wr_idx_next = scan_wr;
        if (scan_end) begin
          status_next = (scan_cnt != '0) ? ST_OK : ST_NOTFOUND;
          if (op == OP_DELETE) begin
            total_next = scan_wr;
          end
        end else begin
          rd_idx_next = rd_idx + CW'(1);
        end
      end
      S_LIST: begin
        if (res_ready && !scan_end) begin
          rd_idx_next = rd_idx + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Outputs: handshake, memory accesses and the result record.
  always_comb begin
    in_ready        = (state == S_IDLE);
    res_valid       = 1'b0;
    res.status      = status;
    res.match_count = '0;
    res.listed_key  = '0;
    res.last        = 1'b1;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = key;
    ram_re          = 1'b0;
    ram_raddr       = '0;
    case (state)
      S_START: begin
        if (op == OP_INSERT) begin
          if (is_empty) begin
            ram_we = 1'b1;
          end else if (!is_full) begin
            ram_re    = 1'b1;
            ram_raddr = total_m1[AW-1:0];
          end
        end else if (!is_empty) begin
          ram_re = 1'b1;
        end
      end
      S_INS_SHIFT: begin
        // Entries not below the new key move up one slot.
        ram_we    = 1'b1;
        ram_waddr = wr_idx[AW-1:0];
        ram_wdata = key_ge ? ram_rdata : key;
        if (key_ge && (wr_idx != CW'(1))) begin
          ram_re    = 1'b1;
          ram_raddr = wr_m2[AW-1:0];
        end
      end
      S_INS_HEAD: begin
        ram_we = 1'b1;
      end
      S_SCAN: begin
        if ((op == OP_DELETE) && !match) begin
          ram_we    = 1'b1;
          ram_waddr = wr_idx[AW-1:0];
          ram_wdata = ram_rdata;
        end
        if (!scan_end) begin
          ram_re    = 1'b1;
          ram_raddr = rd_idx[AW-1:0];
        end
      end
      S_LIST: begin
        res_valid      = 1'b1;
        res.status     = ST_OK;
        res.listed_key = rkey;
        res.last       = scan_end;
        if (res_ready && !scan_end) begin
          ram_re    = 1'b1;
          ram_raddr = rd_idx[AW-1:0];
        end
      end
      S_RESP: begin
        res_valid       = 1'b1;
        res.match_count = cnt_sat;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> test/sorted_key_table_unit_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// sorted_key_table_unit_tb - self-checking bench for the sorted key table
// Drives insert, delete, count and list commands into the s_ channel and
// checks every transfer on the m_ channel against a shadow copy of the table
// kept in a queue. The run covers an empty table, extreme keys, a table
// filled to capacity, and random traffic under four patterns of idling on
// both channels.
// ============================================================================
module sorted_key_table_unit_tb;
  import skt_pkg::*;

  localparam int DEPTH         = 64;
  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 6;
  localparam int CYCLE_LIMIT   = 1_000_000;
  // Longest command is a walk of the whole memory plus set-up; this margin
  // covers anything still in flight once the results are in.
  localparam int SETTLE_CYCLES = 2 * DEPTH + 16;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // opcode[1:0], account_key[33:2], zero[39:34]
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // status[1:0], match_count[8:2], listed_key[40:9],
                          // zero[47:41]
  logic        m_tlast;   // last_of_run

  // Shadow of the table contents, ascending, and the results still owed.
  logic signed [KEY_W-1:0] stored_keys[$];
  skt_res_t                pending_results[$];

  // A small pool of keys, so that duplicates, hits and misses all occur.
  logic signed [KEY_W-1:0] key_pool [0:7];

  int send_idle_pct;
  int recv_stall_pct;
  int error_count;
  int results_checked;
  int full_refusals;
  int cycle_count;
  int commands_by_op [0:3];

  sorted_key_table_unit #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow table. Called once per accepted command: it applies the command
  // to the shadow copy and queues the results the block must produce.
  // --------------------------------------------------------------------------
  function automatic void apply_to_shadow_table(skt_op_t op,
                                                logic signed [KEY_W-1:0] key);
    skt_res_t                res;
    int                      idx;
    int                      hits;
    logic signed [KEY_W-1:0] kept[$];
    res.status      = ST_OK;
    res.match_count = '0;
    res.listed_key  = '0;
    res.last        = 1'b1;
    commands_by_op[op]++;
    case (op)
      OP_INSERT: begin
        if (stored_keys.size() >= DEPTH) begin
          // A full table refuses the key and stays as it was.
          res.status = ST_FULL;
          full_refusals++;
        end else begin
          // New key goes in front of any equal keys already stored.
          idx = 0;
          while (idx < stored_keys.size() && key > stored_keys[idx]) idx++;
          stored_keys.insert(idx, key);
        end
        pending_results.push_back(res);
      end
      OP_DELETE, OP_COUNT: begin
        hits = 0;
        foreach (stored_keys[i]) begin
          if (stored_keys[i] == key) hits++;
          else kept.push_back(stored_keys[i]);
        end
        if (op == OP_DELETE) stored_keys = kept;
        res.status      = (hits != 0) ? ST_OK : ST_NOTFOUND;
        res.match_count = CNT_W'((hits > CNT_MAX) ? CNT_MAX : hits);
        pending_results.push_back(res);
      end
      default: begin
        if (stored_keys.size() == 0) begin
          // An empty listing still gives one result, flagged as last.
          res.status = ST_EMPTY;
          pending_results.push_back(res);
        end else begin
          foreach (stored_keys[i]) begin
            res.listed_key = stored_keys[i];
            res.last       = (i == stored_keys.size() - 1);
            pending_results.push_back(res);
          end
        end
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sends one command. The caller always enters at a rising edge; tvalid is
  // lowered only when the sender decides to idle, so back-to-back commands
  // keep it high without a second assignment in the same step.
  // --------------------------------------------------------------------------
  task automatic send_command(skt_op_t op, logic signed [KEY_W-1:0] key);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, key, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_to_shadow_table(op, key);
  endtask

  // Half the keys come from the pool, a quarter from what is stored now (so
  // deletes and counts mostly hit) and a quarter are fully random.
  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 3))
      0, 1:    return key_pool[$urandom_range(0, 7)];
      2:       return (stored_keys.size() != 0) ?
                      stored_keys[$urandom_range(0, stored_keys.size() - 1)] :
                      KEY_W'($urandom);
      default: return KEY_W'($urandom);
    endcase
  endfunction

  function automatic skt_op_t pick_op();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return OP_INSERT;
    if (roll < 60) return OP_DELETE;
    if (roll < 85) return OP_COUNT;
    return OP_LIST;
  endfunction

  // --------------------------------------------------------------------------
  // Test tasks
  // --------------------------------------------------------------------------

  // Straight after reset the table must be empty: listing reports that, and
  // deleting or counting finds nothing.
  task automatic test_empty_table();
    send_command(OP_LIST, '0);
    send_command(OP_DELETE, 32'sd5);
    send_command(OP_COUNT, 32'sd0);
  endtask

  // Largest and smallest keys, zero and minus one, a duplicate, a new
  // smallest key landing at the head, and removal of the head entry.
  task automatic test_key_extremes();
    send_command(OP_INSERT, 32'sh7FFF_FFFF);
    send_command(OP_INSERT, 32'sh8000_0000);
    send_command(OP_INSERT, 32'sd0);
    send_command(OP_INSERT, -32'sd1);
    send_command(OP_INSERT, 32'sd1);
    send_command(OP_INSERT, 32'sh8000_0000);
    send_command(OP_LIST, 32'shFFFF_FFFF);
    send_command(OP_COUNT, 32'sh8000_0000);
    send_command(OP_COUNT, 32'sd1);
    send_command(OP_COUNT, 32'sd12345);
    send_command(OP_DELETE, 32'sh8000_0000);
    send_command(OP_DELETE, 32'sd99);
    send_command(OP_LIST, '0);
    send_command(OP_DELETE, 32'sh7FFF_FFFF);
    send_command(OP_DELETE, 32'sd0);
    send_command(OP_DELETE, -32'sd1);
    send_command(OP_DELETE, 32'sd1);
    send_command(OP_LIST, '0);
  endtask

  task automatic test_random_mix(int n_commands);
    repeat (n_commands) send_command(pick_op(), pick_key());
  endtask

  // Fills the table to capacity, checks that further inserts are refused,
  // lists all entries and then empties it again by deleting stored keys.
  task automatic test_fill_to_capacity();
    while (stored_keys.size() < DEPTH) send_command(OP_INSERT, pick_key());
    send_command(OP_INSERT, pick_key());
    send_command(OP_INSERT, KEY_W'($urandom));
    send_command(OP_LIST, '0);
    while (stored_keys.size() != 0) begin
      if ($urandom_range(0, 3) == 0) send_command(OP_COUNT, pick_key());
      send_command(OP_DELETE,
                   stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checker. Each transfer on the m_ channel is compared with the
  // oldest result still owed; tready is redrawn every cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_checker
    skt_res_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: status %0d, match_count %0d, listed_key %0d",
                 m_tdata[1:0], m_tdata[8:2], $signed(m_tdata[40:9]));
          error_count++;
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (m_tdata[1:0] !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, m_tdata[1:0]);
            error_count++;
          end
          if (m_tdata[8:2] !== want.match_count) begin
            $error("match_count: expected %0d, actual %0d",
                   want.match_count, m_tdata[8:2]);
            error_count++;
          end
          if (m_tdata[40:9] !== want.listed_key) begin
            $error("listed_key: expected %0d, actual %0d",
                   want.listed_key, $signed(m_tdata[40:9]));
            error_count++;
          end
          if (m_tlast !== want.last) begin
            $error("last_of_run: expected %0d, actual %0d", want.last, m_tlast);
            error_count++;
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    rst             = 1'b1;
    s_tvalid        = 1'b0;
    s_tdata         = '0;
    m_tready        = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    error_count     = 0;
    results_checked = 0;
    full_refusals   = 0;
    foreach (commands_by_op[i]) commands_by_op[i] = 0;

    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7FFF_FFFF;
    key_pool[2] = 32'sd0;
    key_pool[3] = -32'sd1;
    for (int i = 4; i < 8; i++) key_pool[i] = KEY_W'($urandom);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // No idling on either channel.
    test_empty_table();
    test_key_extremes();
    test_random_mix(50);
    test_fill_to_capacity();

    // Sender mostly idle.
    send_idle_pct  = 71;
    recv_stall_pct = 0;
    test_random_mix(60);

    // Receiver mostly stalling, which matters most for long listings.
    send_idle_pct  = 0;
    recv_stall_pct = 71;
    test_fill_to_capacity();
    test_random_mix(30);

    // Both sides idling some of the time.
    send_idle_pct  = 35;
    recv_stall_pct = 35;
    test_random_mix(60);

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d inserts (%0d refused by a full table), %0d deletes, %0d counts, %0d lists",
             commands_by_op[OP_INSERT], full_refusals, commands_by_op[OP_DELETE],
             commands_by_op[OP_COUNT], commands_by_op[OP_LIST]);
    $display("%0d results checked in %0d cycles under four idling patterns",
             results_checked, cycle_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
